/* src/tes_pkg.sv */
`timescale 1ns / 1ps

package tes_pkg;

  localparam int ACTION_W     = 2;
  localparam int SLOT_FIELD_W = 4;
  localparam int INTERVAL_W   = 32;
  localparam int DEADLINE_W   = 48;
  localparam int GAP_W        = 32;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD    = 2'd0,
    ACT_CANCEL = 2'd1,
    ACT_TICK   = 2'd2
  } action_t;

  localparam logic KIND_FIRE    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [GAP_W-1:0] GAP_MAX = '1;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN_INIT,
    ST_SCAN_A,
    ST_SCAN_B,
    ST_DECIDE,
    ST_FIRE,
    ST_GAP
  } seq_state_t;

  typedef struct packed {
    logic we_dl;
    logic we_cfg;
    logic act_set;
    logic act_clr;
  } store_wr_t;

  typedef struct packed {
    logic                    kind;
    logic [SLOT_FIELD_W-1:0] fired_slot;
    logic [DEADLINE_W-1:0]   fired_deadline;
    logic [GAP_W-1:0]        next_gap;
    logic                    none_pending;
    logic                    last;
  } res_t;

endpackage

/* src/tes_if.sv */
`timescale 1ns / 1ps

interface tes_in_if import tes_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ACTION_W-1:0]     action;
  logic [SLOT_FIELD_W-1:0] slot;
  logic [INTERVAL_W-1:0]   interval;
  logic                    repeat_req;

  modport source (output valid, action, slot, interval, repeat_req, input ready);
  modport sink   (input valid, action, slot, interval, repeat_req, output ready);
endinterface

interface tes_out_if import tes_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic [SLOT_FIELD_W-1:0] fired_slot;
  logic [DEADLINE_W-1:0]   fired_deadline;
  logic [GAP_W-1:0]        next_gap;
  logic                    none_pending;
  logic                    last;

  modport source (output valid, kind, fired_slot, fired_deadline, next_gap, none_pending,
                  last, input ready);
  modport sink   (input valid, kind, fired_slot, fired_deadline, next_gap, none_pending,
                  last, output ready);
endinterface

/* src/tes_alu.sv */
`timescale 1ns / 1ps

module tes_alu import tes_pkg::*; #(
  parameter int W = 48
) (
  input  alu_op_t        op,
  input  logic [W-1:0]   a,
  input  logic [W-1:0]   b,
  output logic [W-1:0]   res,
  output logic           borrow,
  output logic           zero
);

  logic [W:0] full;

  always_comb begin
    case (op)
      ALU_ADD: full = {1'b0, a} + {1'b0, b};
      ALU_SUB: full = {1'b0, a} - {1'b0, b};
      default: full = '0;
    endcase
  end

  assign res    = full[W-1:0];
  // top bit of the extended difference is set exactly when a < b
  assign borrow = (op == ALU_SUB) & full[W];
  assign zero   = (res == '0);

endmodule

/* src/tes_store.sv */
`timescale 1ns / 1ps

module tes_store import tes_pkg::*; #(
  parameter int NUM_SLOTS = 16,
  parameter int TIME_BITS = 48,
  parameter int SLOT_W    = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  store_wr_t             wr,
  input  logic [SLOT_W-1:0]     wr_addr,
  input  logic [TIME_BITS-1:0]  wr_dl,
  input  logic [INTERVAL_W-1:0] wr_iv,
  input  logic                  wr_rep,
  input  logic [SLOT_W-1:0]     rd_addr,
  output logic [TIME_BITS-1:0]  rd_dl,
  output logic [INTERVAL_W-1:0] rd_iv,
  output logic                  rd_rep,
  output logic [NUM_SLOTS-1:0]  active
);

  logic [TIME_BITS-1:0]  dl_mem  [NUM_SLOTS];
  logic [INTERVAL_W-1:0] iv_mem  [NUM_SLOTS];
  logic                  rep_mem [NUM_SLOTS];

  logic [TIME_BITS-1:0]  rd_dl_r;
  logic [INTERVAL_W-1:0] rd_iv_r;
  logic                  rd_rep_r;
  logic [NUM_SLOTS-1:0]  active_r;

  always_ff @(posedge clk) begin
    if (wr.we_dl) begin
      dl_mem[wr_addr] <= wr_dl;
    end
    if (wr.we_cfg) begin
      iv_mem[wr_addr]  <= wr_iv;
      rep_mem[wr_addr] <= wr_rep;
    end
    rd_dl_r  <= dl_mem[rd_addr];
    rd_iv_r  <= iv_mem[rd_addr];
    rd_rep_r <= rep_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
    end else if (wr.act_set) begin
      active_r[wr_addr] <= 1'b1;
    end else if (wr.act_clr) begin
      active_r[wr_addr] <= 1'b0;
    end
  end

  assign rd_dl  = rd_dl_r;
  assign rd_iv  = rd_iv_r;
  assign rd_rep = rd_rep_r;
  assign active = active_r;

endmodule

/* src/timer_expiry_scheduler.sv */
`timescale 1ns / 1ps

// Millisecond timer slot scheduler.
// in_ch carries one request: add (arm a slot at now + interval), cancel (free a
// slot) or tick (advance time by one and fire every due slot). out_ch returns
// one fire result per expired slot, in deadline order with ties going to the
// lower slot, then one summary (gap to the earliest pending deadline or
// none_pending) flagged last.
// Every request makes passes over the slot store through one shared
// adder/subtractor, two compares per slot: one pass for an add or cancel, and
// for a tick one more pass after each firing, before the summary is offered.
// in_ch.ready is high only while the sequencer is idle; a new request is
// taken while the previous summary still sits in the output register.
// When out_ch.ready is low the sequencer holds at the fire or summary step
// until the output register frees up; nothing is dropped.
// Reset clears time to zero, frees every slot and empties the output
// register; no clearing pass is needed.
module timer_expiry_scheduler import tes_pkg::*; #(
  parameter int NUM_SLOTS = 16,
  parameter int TIME_BITS = 48
) (
  input  logic      clk,
  input  logic      rst_n,
  tes_in_if.sink    in_ch,
  tes_out_if.source out_ch
);

  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(NUM_SLOTS - 1);

  seq_state_t state_r, state_nxt;

  logic [ACTION_W-1:0]   act_r, act_nxt;
  logic [SLOT_W-1:0]     slot_r, slot_nxt;
  logic                  slot_ok_r, slot_ok_nxt;
  logic [INTERVAL_W-1:0] iv_r, iv_nxt;
  logic                  rep_r, rep_nxt;

  logic [TIME_BITS-1:0]  now_r, now_nxt;
  logic                  tick_r, tick_nxt;
  logic [SLOT_W-1:0]     idx_r, idx_nxt;
  logic [NUM_SLOTS-1:0]  fired_r, fired_nxt;

  logic                  bd_vld_r, bd_vld_nxt;
  logic [TIME_BITS-1:0]  bd_dl_r, bd_dl_nxt;
  logic [SLOT_W-1:0]     bd_idx_r, bd_idx_nxt;
  logic                  ba_vld_r, ba_vld_nxt;
  logic [TIME_BITS-1:0]  ba_dl_r, ba_dl_nxt;

  logic                  out_valid_r, out_valid_nxt;
  res_t                  out_res_r, out_res_nxt;

  alu_op_t               alu_op;
  logic [TIME_BITS-1:0]  alu_a, alu_b, alu_res;
  logic                  alu_borrow, alu_zero;

  store_wr_t             st_wr;
  logic [SLOT_W-1:0]     st_wr_addr, st_rd_addr;
  logic [TIME_BITS-1:0]  rd_dl;
  logic [INTERVAL_W-1:0] rd_iv;
  logic                  rd_rep;
  logic [NUM_SLOTS-1:0]  active;

  logic                  in_accept;
  logic                  out_free;
  logic                  out_load;
  logic                  take_due;
  logic                  take_act;
  logic [GAP_W-1:0]      gap_val;

  tes_alu #(.W(TIME_BITS)) u_alu (
    .op     (alu_op),
    .a      (alu_a),
    .b      (alu_b),
    .res    (alu_res),
    .borrow (alu_borrow),
    .zero   (alu_zero)
  );

  tes_store #(
    .NUM_SLOTS (NUM_SLOTS),
    .TIME_BITS (TIME_BITS),
    .SLOT_W    (SLOT_W)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (st_wr),
    .wr_addr (st_wr_addr),
    .wr_dl   (alu_res),
    .wr_iv   (iv_r),
    .wr_rep  (rep_r),
    .rd_addr (st_rd_addr),
    .rd_dl   (rd_dl),
    .rd_iv   (rd_iv),
    .rd_rep  (rd_rep),
    .active  (active)
  );

  assign in_accept = in_ch.valid & in_ch.ready;
  assign out_free  = ~out_valid_r | out_ch.ready;

  // due candidate: first hit needs deadline <= now, later hits strictly earlier
  assign take_due = tick_r & active[idx_r] & ~fired_r[idx_r] &
                    (bd_vld_r ? alu_borrow : (alu_borrow | alu_zero));
  assign take_act = active[idx_r] & (~ba_vld_r | alu_borrow);

  // gap is zero when the earliest deadline is not ahead of now
  always_comb begin
    gap_val = '0;
    if (ba_vld_r && !alu_borrow && !alu_zero) begin
      if (alu_res > TIME_BITS'(GAP_MAX)) begin
        gap_val = GAP_MAX;
      end else begin
        gap_val = GAP_W'(alu_res);
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:      if (in_ch.valid) state_nxt = ST_EXEC;
      ST_EXEC:      state_nxt = ST_SCAN_INIT;
      ST_SCAN_INIT: state_nxt = ST_SCAN_A;
      ST_SCAN_A:    state_nxt = ST_SCAN_B;
      ST_SCAN_B:    state_nxt = (idx_r == LAST_IDX) ? ST_DECIDE : ST_SCAN_A;
      ST_DECIDE:    state_nxt = bd_vld_r ? ST_FIRE : ST_GAP;
      ST_FIRE:      if (out_free) state_nxt = ST_SCAN_INIT;
      ST_GAP:       if (out_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // control outputs: handshake, shared unit operands, store access
  always_comb begin
    in_ch.ready = 1'b0;
    out_load    = 1'b0;
    alu_op      = ALU_ADD;
    alu_a       = now_r;
    alu_b       = TIME_BITS'(iv_r);
    st_wr       = '0;
    st_wr_addr  = slot_r;
    st_rd_addr  = bd_idx_r;
    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
      end
      ST_EXEC: begin
        case (act_r)
          ACT_ADD: begin
            if (slot_ok_r) begin
              st_wr.we_dl   = 1'b1;
              st_wr.we_cfg  = 1'b1;
              st_wr.act_set = 1'b1;
            end
          end
          ACT_CANCEL: begin
            if (slot_ok_r) st_wr.act_clr = 1'b1;
          end
          ACT_TICK: begin
            alu_b = TIME_BITS'(1);
          end
          default: ;
        endcase
      end
      ST_SCAN_INIT: begin
        st_rd_addr = '0;
      end
      ST_SCAN_A: begin
        alu_op     = ALU_SUB;
        alu_a      = rd_dl;
        alu_b      = bd_vld_r ? bd_dl_r : now_r;
        st_rd_addr = idx_r;
      end
      ST_SCAN_B: begin
        alu_op     = ALU_SUB;
        alu_a      = rd_dl;
        alu_b      = ba_dl_r;
        st_rd_addr = idx_r + SLOT_W'(1);
      end
      ST_FIRE: begin
        // re-arm a repeating slot at now + interval, free a one-shot
        alu_b      = TIME_BITS'(rd_iv);
        st_wr_addr = bd_idx_r;
        if (out_free) begin
          out_load = 1'b1;
          if (rd_rep) begin
            st_wr.we_dl = 1'b1;
          end else begin
            st_wr.act_clr = 1'b1;
          end
        end
      end
      ST_GAP: begin
        alu_op = ALU_SUB;
        alu_a  = ba_dl_r;
        alu_b  = now_r;
        if (out_free) out_load = 1'b1;
      end
      default: ;
    endcase
  end

  // datapath next values
  always_comb begin
    act_nxt     = act_r;
    slot_nxt    = slot_r;
    slot_ok_nxt = slot_ok_r;
    iv_nxt      = iv_r;
    rep_nxt     = rep_r;
    now_nxt     = now_r;
    tick_nxt    = tick_r;
    idx_nxt     = idx_r;
    fired_nxt   = fired_r;
    bd_vld_nxt  = bd_vld_r;
    bd_dl_nxt   = bd_dl_r;
    bd_idx_nxt  = bd_idx_r;
    ba_vld_nxt  = ba_vld_r;
    ba_dl_nxt   = ba_dl_r;
    out_res_nxt = out_res_r;

    if (in_accept) begin
      act_nxt     = in_ch.action;
      slot_nxt    = SLOT_W'(in_ch.slot);
      slot_ok_nxt = (32'(in_ch.slot) < 32'(NUM_SLOTS));
      iv_nxt      = in_ch.interval;
      rep_nxt     = in_ch.repeat_req;
    end

    case (state_r)
      ST_EXEC: begin
        fired_nxt = '0;
        tick_nxt  = (act_r == ACT_TICK);
        if (act_r == ACT_TICK) now_nxt = alu_res;
      end
      ST_SCAN_INIT: begin
        idx_nxt    = '0;
        bd_vld_nxt = 1'b0;
        ba_vld_nxt = 1'b0;
      end
      ST_SCAN_A: begin
        if (take_due) begin
          bd_vld_nxt = 1'b1;
          bd_dl_nxt  = rd_dl;
          bd_idx_nxt = idx_r;
        end
      end
      ST_SCAN_B: begin
        if (take_act) begin
          ba_vld_nxt = 1'b1;
          ba_dl_nxt  = rd_dl;
        end
        if (idx_r != LAST_IDX) idx_nxt = idx_r + SLOT_W'(1);
      end
      ST_FIRE: begin
        if (out_free) fired_nxt[bd_idx_r] = 1'b1;
        out_res_nxt.kind           = KIND_FIRE;
        out_res_nxt.fired_slot     = SLOT_FIELD_W'(bd_idx_r);
        out_res_nxt.fired_deadline = DEADLINE_W'(bd_dl_r);
        out_res_nxt.next_gap       = '0;
        out_res_nxt.none_pending   = 1'b0;
        out_res_nxt.last           = 1'b0;
      end
      ST_GAP: begin
        if (out_free) bd_vld_nxt = 1'b0;
        out_res_nxt.kind           = KIND_SUMMARY;
        out_res_nxt.fired_slot     = '0;
        out_res_nxt.fired_deadline = '0;
        out_res_nxt.next_gap       = gap_val;
        out_res_nxt.none_pending   = ~ba_vld_r;
        out_res_nxt.last           = 1'b1;
      end
      default: ;
    endcase

    if (!out_load) out_res_nxt = out_res_r;

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      now_r       <= '0;
      tick_r      <= 1'b0;
      idx_r       <= '0;
      fired_r     <= '0;
      bd_vld_r    <= 1'b0;
      ba_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      now_r       <= now_nxt;
      tick_r      <= tick_nxt;
      idx_r       <= idx_nxt;
      fired_r     <= fired_nxt;
      bd_vld_r    <= bd_vld_nxt;
      ba_vld_r    <= ba_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r     <= act_nxt;
    slot_r    <= slot_nxt;
    slot_ok_r <= slot_ok_nxt;
    iv_r      <= iv_nxt;
    rep_r     <= rep_nxt;
    bd_dl_r   <= bd_dl_nxt;
    bd_idx_r  <= bd_idx_nxt;
    ba_dl_r   <= ba_dl_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.kind           = out_res_r.kind;
  assign out_ch.fired_slot     = out_res_r.fired_slot;
  assign out_ch.fired_deadline = out_res_r.fired_deadline;
  assign out_ch.next_gap       = out_res_r.next_gap;
  assign out_ch.none_pending   = out_res_r.none_pending;
  assign out_ch.last           = out_res_r.last;

  a_fired_only_in_tick: assert property (
    @(posedge clk) disable iff (!rst_n) !tick_r |-> (fired_r == '0)
  ) else $error("fired mask set outside a tick");

  a_due_not_ahead: assert property (
    @(posedge clk) disable iff (!rst_n) bd_vld_r |-> (bd_dl_r <= now_r)
  ) else $error("due candidate deadline lies after current time");

  a_fire_needs_tick: assert property (
    @(posedge clk) disable iff (!rst_n) (state_r == ST_FIRE) |-> tick_r
  ) else $error("fire step reached outside a tick");

  a_fire_marks_slot: assert property (
    @(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIRE && out_free) |=> fired_r[$past(bd_idx_r)]
  ) else $error("fired slot not excluded from later passes");

endmodule

/* bench/timer_expiry_checker.sv */
`timescale 1ns / 1ps

module timer_expiry_checker import tes_pkg::*; #(
  parameter int NUM_SLOTS = 16,
  parameter int TIME_BITS = 48
) (
  input  logic clk,
  input  logic rst_n,
  tes_in_if    req_mon,
  tes_out_if   res_mon,
  output int   fail_count,
  output int   events_outstanding
);

  localparam int MAX_REPORTS = 40;

  logic [TIME_BITS-1:0]  now_ms;
  logic [TIME_BITS-1:0]  slot_dl   [NUM_SLOTS];
  logic [INTERVAL_W-1:0] slot_ival [NUM_SLOTS];
  logic                  slot_rep  [NUM_SLOTS];
  logic                  slot_on   [NUM_SLOTS];
  res_t                  slot_events [$];
  res_t                  head_res;

  task automatic log_mismatch(input string msg);
    if (fail_count < MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  // Update the timer slots for one request and queue the fire and summary results it causes.
  task automatic apply_timer_action(input logic [ACTION_W-1:0]     act,
                                    input logic [SLOT_FIELD_W-1:0] sl,
                                    input logic [INTERVAL_W-1:0]   ival,
                                    input logic                    rep);
    logic                 due [NUM_SLOTS];
    int                   pick;
    logic [TIME_BITS-1:0] diff;
    res_t                 r;
    case (act)
      ACT_ADD: begin
        if (sl < NUM_SLOTS) begin
          slot_dl[sl]   = now_ms + ival;
          slot_ival[sl] = ival;
          slot_rep[sl]  = rep;
          slot_on[sl]   = 1'b1;
        end
      end
      ACT_CANCEL: begin
        if (sl < NUM_SLOTS) slot_on[sl] = 1'b0;
      end
      ACT_TICK: begin
        now_ms = now_ms + 1'b1;
        // freeze the due set first: a re-armed slot never fires twice in one tick
        for (int i = 0; i < NUM_SLOTS; i++) due[i] = slot_on[i] && (slot_dl[i] <= now_ms);
        do begin
          pick = -1;
          for (int i = 0; i < NUM_SLOTS; i++)
            if (due[i] && (pick < 0 || slot_dl[i] < slot_dl[pick])) pick = i;
          if (pick >= 0) begin
            due[pick] = 1'b0;
            r = '0;
            r.kind           = KIND_FIRE;
            r.fired_slot     = pick[SLOT_FIELD_W-1:0];
            r.fired_deadline = DEADLINE_W'(slot_dl[pick]);
            slot_events.push_back(r);
            if (slot_rep[pick]) slot_dl[pick] = now_ms + slot_ival[pick];
            else slot_on[pick] = 1'b0;
          end
        end while (pick >= 0);
      end
      default: ;
    endcase

    pick = -1;
    for (int i = 0; i < NUM_SLOTS; i++)
      if (slot_on[i] && (pick < 0 || slot_dl[i] < slot_dl[pick])) pick = i;
    r = '0;
    r.kind         = KIND_SUMMARY;
    r.last         = 1'b1;
    r.none_pending = (pick < 0);
    // a deadline at or before now leaves the gap at zero
    if (pick >= 0 && slot_dl[pick] > now_ms) begin
      diff = slot_dl[pick] - now_ms;
      r.next_gap = (diff > GAP_MAX) ? GAP_MAX : diff[GAP_W-1:0];
    end
    slot_events.push_back(r);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      now_ms = '0;
      for (int i = 0; i < NUM_SLOTS; i++) slot_on[i] = 1'b0;
      slot_events.delete();
      fail_count = 0;
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        if (slot_events.size() == 0) begin
          log_mismatch($sformatf("result with nothing awaited: kind %0d slot %0d last %0d",
                                 res_mon.kind, res_mon.fired_slot, res_mon.last));
        end else begin
          head_res = slot_events.pop_front();
          if (res_mon.kind !== head_res.kind)
            log_mismatch($sformatf("kind got %0d want %0d", res_mon.kind, head_res.kind));
          if (res_mon.fired_slot !== head_res.fired_slot)
            log_mismatch($sformatf("fired_slot got %0d want %0d",
                                   res_mon.fired_slot, head_res.fired_slot));
          if (res_mon.fired_deadline !== head_res.fired_deadline)
            log_mismatch($sformatf("fired_deadline got %0d want %0d",
                                   res_mon.fired_deadline, head_res.fired_deadline));
          if (res_mon.next_gap !== head_res.next_gap)
            log_mismatch($sformatf("next_gap got %0d want %0d",
                                   res_mon.next_gap, head_res.next_gap));
          if (res_mon.none_pending !== head_res.none_pending)
            log_mismatch($sformatf("none_pending got %0d want %0d",
                                   res_mon.none_pending, head_res.none_pending));
          if (res_mon.last !== head_res.last)
            log_mismatch($sformatf("last got %0d want %0d", res_mon.last, head_res.last));
        end
      end
      if (req_mon.valid && req_mon.ready)
        apply_timer_action(req_mon.action, req_mon.slot, req_mon.interval, req_mon.repeat_req);
    end
    events_outstanding <= slot_events.size();
  end

endmodule

/* bench/tb_timer_expiry_scheduler.sv */
`timescale 1ns / 1ps

module tb_timer_expiry_scheduler;
  import tes_pkg::*;

  localparam int NUM_SLOTS     = 16;
  localparam int TIME_BITS     = 48;
  localparam int TOTAL_ITEMS   = 460;
  localparam int HOLD_AT       = 150;
  localparam int DRAIN_AT      = 300;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT   = 4000;

  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  logic clk;
  logic rst_n;
  logic hold_req;
  logic hold_done;
  int   fail_count;
  int   events_outstanding;
  int   items_sent;

  tes_in_if  in_ch ();
  tes_out_if out_ch ();

  timer_expiry_scheduler #(
    .NUM_SLOTS(NUM_SLOTS),
    .TIME_BITS(TIME_BITS)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  timer_expiry_checker #(
    .NUM_SLOTS(NUM_SLOTS),
    .TIME_BITS(TIME_BITS)
  ) expiry_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_mon           (in_ch),
    .res_mon           (out_ch),
    .fail_count        (fail_count),
    .events_outstanding(events_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one request, hold it until taken, then idle for a random gap.
  task automatic send_request(input logic [ACTION_W-1:0]     act,
                              input logic [SLOT_FIELD_W-1:0] sl,
                              input logic [INTERVAL_W-1:0]   ival,
                              input logic                    rep);
    int gap;
    int roll;
    in_ch.valid      <= 1'b1;
    in_ch.action     <= act;
    in_ch.slot       <= sl;
    in_ch.interval   <= ival;
    in_ch.repeat_req <= rep;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    if (act != ACT_UNUSED) items_sent++;
    roll = $urandom_range(0, 99);
    // keep pushing while the receiver holds off
    if (hold_req && !hold_done) gap = 0;
    else if (roll < 45) gap = 0;
    else if (roll < 88) gap = $urandom_range(1, 4);
    else if (roll < 97) gap = $urandom_range(5, 20);
    else gap = $urandom_range(40, 150);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [INTERVAL_W-1:0] pick_interval();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return $urandom_range(0, 8);
    else if (roll < 82) return $urandom_range(9, 60);
    else if (roll < 95) return $urandom;
    else if (roll < 98) return '0;
    else return '1;
  endfunction

  // Arm every slot at once, then tick so that many fire together.
  task automatic full_load(input bit all_zero);
    for (int s = 0; s < NUM_SLOTS; s++)
      send_request(ACT_ADD, s[SLOT_FIELD_W-1:0],
                   all_zero ? 32'd0 : 32'($urandom_range(0, 3)), 1'($urandom));
    repeat ($urandom_range(2, 4)) send_request(ACT_TICK, 4'($urandom), $urandom, 1'($urandom));
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (events_outstanding != 0) @(posedge clk);
  endtask

  initial begin
    int seq;
    bit drained;
    drained          = 1'b0;
    items_sent       = 0;
    rst_n           <= 1'b0;
    hold_req        <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.action    <= ACT_ADD;
    in_ch.slot      <= '0;
    in_ch.interval  <= '0;
    in_ch.repeat_req <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(ACT_TICK, 4'd9, 32'hFFFF_FFFF, 1'b1);    // tick with nothing armed
    send_request(ACT_UNUSED, 4'd15, 32'hFFFF_FFFF, 1'b1); // unused code: summary only
    send_request(ACT_CANCEL, 4'd5, 32'd0, 1'b0);          // cancel of a free slot
    send_request(ACT_ADD, 4'd15, 32'hFFFF_FFFF, 1'b0);    // longest delay
    send_request(ACT_ADD, 4'd0, 32'd0, 1'b1);             // repeating zero interval
    send_request(ACT_ADD, 4'd3, 32'd2, 1'b0);
    send_request(ACT_ADD, 4'd12, 32'd2, 1'b0);            // ties with slot 3
    send_request(ACT_ADD, 4'd7, 32'd1, 1'b1);
    send_request(ACT_TICK, 4'd0, 32'd0, 1'b0);
    send_request(ACT_TICK, 4'd15, 32'd0, 1'b0);
    send_request(ACT_ADD, 4'd7, 32'd3, 1'b0);             // overwrite an armed slot
    send_request(ACT_CANCEL, 4'd0, 32'hFFFF_FFFF, 1'b1);
    send_request(ACT_TICK, 4'd0, 32'd0, 1'b0);
    send_request(ACT_TICK, 4'd0, 32'd0, 1'b0);
    send_request(ACT_TICK, 4'd0, 32'd0, 1'b0);
    send_request(ACT_CANCEL, 4'd15, 32'd0, 1'b0);
    full_load(1'b1);

    while (items_sent < TOTAL_ITEMS) begin
      if (items_sent >= HOLD_AT && hold_req !== 1'b1) hold_req <= 1'b1;
      if (items_sent >= DRAIN_AT && !drained) begin
        drain_results();
        drained = 1'b1;
      end
      seq = $urandom_range(0, 99);
      if (seq < 55) begin
        repeat ($urandom_range(1, 5))
          send_request(ACT_ADD, 4'($urandom), pick_interval(), 1'($urandom));
        repeat ($urandom_range(1, 8))
          send_request(ACT_TICK, 4'($urandom), $urandom, 1'($urandom));
      end else if (seq < 70) begin
        repeat ($urandom_range(1, 3))
          send_request(ACT_CANCEL, 4'($urandom), $urandom, 1'($urandom));
        send_request(ACT_TICK, 4'($urandom), $urandom, 1'($urandom));
      end else if (seq < 74) begin
        full_load(1'b0);
      end else begin
        send_request(2'($urandom), 4'($urandom), $urandom, 1'($urandom));
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  // Result side: random back-pressure plus one long hold-off.
  initial begin
    int roll;
    out_ch.ready <= 1'b0;
    hold_done    <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_req === 1'b1 && hold_done !== 1'b1) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done    <= 1'b1;
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
          out_ch.ready <= 1'b1;
          repeat ($urandom_range(1, 30)) @(posedge clk);
        end else if (roll < 93) begin
          out_ch.ready <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else begin
          out_ch.ready <= 1'b0;
          repeat ($urandom_range(20, 120)) @(posedge clk);
        end
      end
    end
  end

  // End the run if neither channel moves for too long.
  initial begin
    int stall_cycles;
    stall_cycles = 0;
    forever begin
      @(posedge clk);
      if (rst_n !== 1'b1 || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

endmodule
